// ----- hw/rtl/zobrist_board_hash_macros.svh -----
// Assertion macros used by the Zobrist hash datapath.
`ifndef ZOBRIST_BOARD_HASH_MACROS_SVH
`define ZOBRIST_BOARD_HASH_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ZBH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ZBH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/zbh_pkg.sv -----
// Shared constants, codes and control types of the Zobrist hash block.
package zbh_pkg;

    localparam int KEY_W       = 64;
    localparam int SQUARES     = 64;
    localparam int SQ_W        = 6;
    localparam int PIECE_W     = 4;
    localparam int PIECE_KINDS = 12;
    localparam int CASTLE_CNT  = 16;
    localparam int CASTLE_W    = 4;
    localparam int EP_BASE     = PIECE_KINDS * SQUARES;
    localparam int SIDE_ADDR   = EP_BASE + SQUARES;
    localparam int CASTLE_BASE = SIDE_ADDR + 1;
    localparam int TABLE_DEPTH = CASTLE_BASE + CASTLE_CNT;
    localparam int ADDR_W      = 10;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_FOLD   = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_SIDE,
        ST_EP,
        ST_CASTLE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_SQUARE,
        RD_SIDE,
        RD_EP,
        RD_CASTLE
    } t_rd_src;

    typedef struct packed {
        logic    wr_en;
        logic    load_fold;
        logic    load_fin;
        t_rd_src rd_src;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic bits_nz;
    } t_dp_stat;

endpackage

// ----- hw/rtl/zbh_ctrl.sv -----
// Controller state machine sequencing key writes, folds and finish reads.
module zbh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_operation,
    input  zbh_pkg::t_dp_stat i_stat,
    output logic             o_busy,
    output zbh_pkg::t_dp_cmd o_cmd
);
    import zbh_pkg::*;

    t_state r_state;
    t_state n_state;
    t_op    op;

    assign op     = t_op'(i_operation);
    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{wr_en: 1'b0, load_fold: 1'b0, load_fin: 1'b0,
                    rd_src: RD_NONE, emit: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (op)
                        OP_WRITE: begin
                            o_cmd.wr_en = 1'b1;
                        end
                        OP_FOLD: begin
                            o_cmd.load_fold = 1'b1;
                            n_state         = ST_FOLD;
                        end
                        OP_FINISH: begin
                            o_cmd.load_fin = 1'b1;
                            n_state        = ST_SIDE;
                        end
                        OP_NONE: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FOLD: begin
                if (i_stat.bits_nz) begin
                    o_cmd.rd_src = RD_SQUARE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SIDE: begin
                o_cmd.rd_src = RD_SIDE;
                n_state      = ST_EP;
            end
            ST_EP: begin
                o_cmd.rd_src = RD_EP;
                n_state      = ST_CASTLE;
            end
            ST_CASTLE: begin
                o_cmd.rd_src = RD_CASTLE;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/zbh_dp.sv -----
// Datapath: key table, square scanner, accumulator and hash output register.
`include "zobrist_board_hash_macros.svh"

module zbh_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  zbh_pkg::t_dp_cmd             i_cmd,
    input  logic [zbh_pkg::ADDR_W-1:0]   i_key_index,
    input  logic [zbh_pkg::KEY_W-1:0]    i_key_value,
    input  logic [zbh_pkg::PIECE_W-1:0]  i_piece,
    input  logic [zbh_pkg::SQUARES-1:0]  i_bitboard,
    input  logic                         i_white_to_move,
    input  logic                         i_ep_valid,
    input  logic [zbh_pkg::SQ_W-1:0]     i_ep_square,
    input  logic [zbh_pkg::CASTLE_W-1:0] i_castle_rights,
    output zbh_pkg::t_dp_stat            o_stat,
    output logic [zbh_pkg::KEY_W-1:0]    o_hash,
    output logic                         o_hash_valid
);
    import zbh_pkg::*;

    logic [KEY_W-1:0]    mem [TABLE_DEPTH];

    logic [SQUARES-1:0]  r_bits;
    logic [PIECE_W-1:0]  r_piece;
    logic                r_white;
    logic                r_ep_valid;
    logic [SQ_W-1:0]     r_ep_sq;
    logic [CASTLE_W-1:0] r_castle;
    logic [KEY_W-1:0]    r_rdata;
    logic                r_pend;
    logic [KEY_W-1:0]    r_acc;
    logic [KEY_W-1:0]    r_hash;
    logic                r_hash_valid;

    logic [SQUARES-1:0]  low_bit;
    logic [SQ_W-1:0]     low_idx;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_use;
    logic                rd_en;
    logic [KEY_W-1:0]    acc_x;

    assign low_bit = r_bits & (~r_bits + {{(SQUARES-1){1'b0}}, 1'b1});

    always_comb begin
        low_idx = '0;
        for (int b = 0; b < SQ_W; b++) begin
            for (int n = 0; n < SQUARES; n++) begin
                if (((n >> b) & 1) == 1) begin
                    low_idx[b] = low_idx[b] | low_bit[n];
                end
            end
        end
    end

    always_comb begin
        rd_addr = '0;
        rd_use  = 1'b0;
        unique case (i_cmd.rd_src)
            RD_NONE: begin
                rd_use = 1'b0;
            end
            RD_SQUARE: begin
                rd_addr = {r_piece, low_idx};
                rd_use  = 1'b1;
            end
            RD_SIDE: begin
                rd_addr = ADDR_W'(SIDE_ADDR);
                rd_use  = r_white;
            end
            RD_EP: begin
                rd_addr = ADDR_W'(EP_BASE) + ADDR_W'(r_ep_sq);
                rd_use  = r_ep_valid;
            end
            RD_CASTLE: begin
                rd_addr = ADDR_W'(CASTLE_BASE) + ADDR_W'(r_castle);
                rd_use  = 1'b1;
            end
            default: begin
                rd_use = 1'b0;
            end
        endcase
    end

    assign rd_en = (i_cmd.rd_src != RD_NONE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && (i_key_index < ADDR_W'(TABLE_DEPTH))) begin
            mem[i_key_index] <= i_key_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fold) begin
            r_bits  <= (i_piece < PIECE_W'(PIECE_KINDS)) ? i_bitboard : '0;
            r_piece <= i_piece;
        end else if (i_cmd.rd_src == RD_SQUARE) begin
            r_bits <= r_bits & ~low_bit;
        end
        if (i_cmd.load_fin) begin
            r_white    <= i_white_to_move;
            r_ep_valid <= i_ep_valid;
            r_ep_sq    <= i_ep_square;
            r_castle   <= i_castle_rights;
        end
    end

    assign acc_x = r_pend ? (r_acc ^ r_rdata) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_acc        <= '0;
            r_hash_valid <= 1'b0;
        end else begin
            r_pend       <= rd_en && rd_use;
            r_hash_valid <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_acc <= '0;
            end else begin
                r_acc <= acc_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_hash <= acc_x;
        end
    end

    assign o_stat.bits_nz = (r_bits != '0);
    assign o_hash         = r_hash;
    assign o_hash_valid   = r_hash_valid;

    `ZBH_ASSERT_IMPL(a_strobe_follows_emit, r_hash_valid, $past(i_cmd.emit), "strobe without emit")
    `ZBH_ASSERT_IMPL(a_acc_cleared_on_emit, r_hash_valid, r_acc == '0, "accumulator not cleared")
    `ZBH_ASSERT_NEVER(a_scan_empty_board, (i_cmd.rd_src == RD_SQUARE) && (r_bits == '0), "square read with no set square")
    `ZBH_ASSERT_NEVER(a_emit_with_read, i_cmd.emit && rd_en, "emit overlaps a key read")

endmodule

// ----- hw/rtl/zobrist_board_hash.sv -----
// Top level of the 64-bit Zobrist position hash block.
// Assert start with an operation while busy is low; that edge takes the beat. A key write
// finishes in the accept cycle and leaves busy low. A fold of a piece bitboard keeps busy
// high while its set squares are scanned and drops it once none is left, since each set
// square costs one read of the key table. A finish keeps busy high through the side, en
// passant and castling key reads, then the emit; o_hash_valid pulses for one cycle after the emit
// with the hash. The receiver cannot stall: take o_hash whenever o_hash_valid is high.
// Entries of the key table read before they are written give undefined hash bits.
module zobrist_board_hash (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic [zbh_pkg::ADDR_W-1:0]   i_key_index,
    input  logic [zbh_pkg::KEY_W-1:0]    i_key_value,
    input  logic [zbh_pkg::PIECE_W-1:0]  i_piece,
    input  logic [zbh_pkg::SQUARES-1:0]  i_bitboard,
    input  logic                         i_white_to_move,
    input  logic                         i_ep_valid,
    input  logic [zbh_pkg::SQ_W-1:0]     i_ep_square,
    input  logic [zbh_pkg::CASTLE_W-1:0] i_castle_rights,
    output logic [zbh_pkg::KEY_W-1:0]    o_hash,
    output logic                         o_hash_valid
);
    import zbh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    zbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    zbh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_key_index     (i_key_index),
        .i_key_value     (i_key_value),
        .i_piece         (i_piece),
        .i_bitboard      (i_bitboard),
        .i_white_to_move (i_white_to_move),
        .i_ep_valid      (i_ep_valid),
        .i_ep_square     (i_ep_square),
        .i_castle_rights (i_castle_rights),
        .o_stat          (stat),
        .o_hash          (o_hash),
        .o_hash_valid    (o_hash_valid)
    );

endmodule
